// ----- sv/stmf_pkg.sv -----
// ----------------------------------------------------------------------------
// stmf_pkg: shared types and constants for the trimmed-mean filter
// Sample width and the command and status bundles that link the controller
// and the datapath.
// ----------------------------------------------------------------------------
package stmf_pkg;

  localparam int DATA_W = 16;

  typedef struct packed {
    logic accept;    // write the new word into the window, clear the scan
    logic scan;      // visit one window entry
    logic ext;       // add up the four extremes
    logic num;       // form the rounded numerator
    logic mag;       // split numerator into sign and magnitude
    logic mul;       // multiply the magnitude by the reciprocal
    logic quot;      // take the estimated quotient
    logic prod;      // multiply the estimate back by the divisor
    logic fix;       // correct the estimate by one if needed
    logic load_out;  // load the output register
  } stmf_cmd_t;

  typedef struct packed {
    logic scan_last; // the current scan entry is the last one
  } stmf_sts_t;

endpackage

// ----- sv/stmf_ctrl.sv -----
// ----------------------------------------------------------------------------
// stmf_ctrl: sequencer of the trimmed-mean filter
// Steps one word through scan, trim, divide and output, and owns the
// handshake on both streams.
// ----------------------------------------------------------------------------
module stmf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  stmf_pkg::stmf_sts_t sts_i,
  output stmf_pkg::stmf_cmd_t cmd_o
);
  import stmf_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_SCAN = 10'b00_0000_0010,
    ST_EXT  = 10'b00_0000_0100,
    ST_NUM  = 10'b00_0000_1000,
    ST_MAG  = 10'b00_0001_0000,
    ST_MUL  = 10'b00_0010_0000,
    ST_QUOT = 10'b00_0100_0000,
    ST_PROD = 10'b00_1000_0000,
    ST_FIX  = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_EXT;
        end
      end
      ST_EXT: begin
        cmd_o.ext = 1'b1;
        state_d   = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.num = 1'b1;
        state_d   = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.mag = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_QUOT;
      end
      ST_QUOT: begin
        cmd_o.quot = 1'b1;
        state_d    = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        // The result waits here until the output register is free.
        if (!out_valid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

endmodule

// ----- sv/stmf_dp.sv -----
// ----------------------------------------------------------------------------
// stmf_dp: datapath of the trimmed-mean filter
// Window store, scan for sum and the two smallest and largest values, and
// division of the rounded trimmed sum by a constant via a reciprocal.
// ----------------------------------------------------------------------------
module stmf_dp #(
  parameter int WINDOW = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic signed [stmf_pkg::DATA_W-1:0] cfg_wdata_i,
  input  logic signed [stmf_pkg::DATA_W-1:0] sample_i,
  input  stmf_pkg::stmf_cmd_t               cmd_i,
  output stmf_pkg::stmf_sts_t               sts_o,
  output logic signed [stmf_pkg::DATA_W-1:0] filtered_o
);
  import stmf_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);
  localparam int KEPT  = WINDOW - 4;
  localparam int HALF  = KEPT / 2;
  localparam int SUM_W = DATA_W + IDX_W + 1;
  localparam int MAG_W = SUM_W - 1;
  localparam int EXT_W = DATA_W + 2;
  localparam logic [MAG_W:0] RECIP = (MAG_W + 1)'((64'd1 << MAG_W) / KEPT);

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

  logic signed [DATA_W-1:0] init_q;
  logic [WINDOW-1:0]        vld_q;
  logic signed [DATA_W-1:0] win_q [WINDOW];
  logic [IDX_W-1:0]         wptr_q;
  logic [IDX_W-1:0]         idx_q;
  logic signed [SUM_W-1:0]  total_q;
  logic signed [DATA_W-1:0] min1_q, min2_q, max1_q, max2_q;
  logic signed [EXT_W-1:0]  ext_q;
  logic signed [SUM_W-1:0]  num_q;
  logic [MAG_W-1:0]         mag_q;
  logic                     neg_q;
  logic [2*MAG_W:0]         prod_q;
  logic [MAG_W-1:0]         q0_q;
  logic [MAG_W-1:0]         qd_q;
  logic [MAG_W-1:0]         q_q;
  logic signed [DATA_W-1:0] out_q;

  logic signed [DATA_W-1:0] rd_val;
  logic [MAG_W-1:0]         rem;

  // An entry not written since the last fill reads as the fill level.
  assign rd_val = vld_q[idx_q] ? win_q[idx_q] : init_q;
  assign rem    = mag_q - qd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
      vld_q  <= '0;
      wptr_q <= '0;
    end else if (cfg_we_i) begin
      init_q <= cfg_wdata_i;
      vld_q  <= '0;
      wptr_q <= '0;
    end else if (cmd_i.accept) begin
      vld_q[wptr_q] <= 1'b1;
      wptr_q        <= (wptr_q == IDX_W'(WINDOW - 1)) ? '0 : wptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      win_q[wptr_q] <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q   <= '0;
      total_q <= '0;
      min1_q  <= VAL_MAX;
      min2_q  <= VAL_MAX;
      max1_q  <= VAL_MIN;
      max2_q  <= VAL_MIN;
    end else if (cmd_i.scan) begin
      idx_q   <= idx_q + 1'b1;
      total_q <= total_q + SUM_W'(rd_val);
      if (rd_val < min1_q) begin
        min2_q <= min1_q;
        min1_q <= rd_val;
      end else if (rd_val < min2_q) begin
        min2_q <= rd_val;
      end
      if (rd_val > max1_q) begin
        max2_q <= max1_q;
        max1_q <= rd_val;
      end else if (rd_val > max2_q) begin
        max2_q <= rd_val;
      end
    end
  end

  // Trimmed sum is the total less the two smallest and two largest values.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ext) begin
      ext_q <= EXT_W'(min1_q) + EXT_W'(min2_q) + EXT_W'(max1_q) + EXT_W'(max2_q);
    end
    if (cmd_i.num) begin
      num_q <= total_q - SUM_W'(ext_q) + SUM_W'(HALF);
    end
    if (cmd_i.mag) begin
      neg_q <= num_q[SUM_W-1];
      mag_q <= num_q[SUM_W-1] ? MAG_W'(-num_q) : MAG_W'(num_q);
    end
    if (cmd_i.mul) begin
      prod_q <= mag_q * RECIP;
    end
    // The estimate is at most one below the true quotient.
    if (cmd_i.quot) begin
      q0_q <= prod_q[2*MAG_W-1:MAG_W];
    end
    if (cmd_i.prod) begin
      qd_q <= MAG_W'(q0_q * KEPT);
    end
    if (cmd_i.fix) begin
      q_q <= (rem >= MAG_W'(KEPT)) ? q0_q + 1'b1 : q0_q;
    end
    if (cmd_i.load_out) begin
      out_q <= neg_q ? DATA_W'(-q_q) : DATA_W'(q_q);
    end
  end

  assign sts_o.scan_last = (idx_q == IDX_W'(WINDOW - 1));
  assign filtered_o      = out_q;

endmodule

// ----- sv/sliding_trimmed_mean_filter.sv -----
// ----------------------------------------------------------------------------
// sliding_trimmed_mean_filter: trimmed mean over a sliding sample window
// Each input word carries one signed 16-bit sample (s_axis_tdata). It
// replaces the oldest of WINDOW stored samples; the window is then scanned
// for its sum and its two smallest and two largest values, which are
// dropped. The output word (m_axis_tdata) is the remaining sum plus half
// the kept count, divided by the kept count WINDOW-4 with truncation
// toward zero.
// One word is processed at a time: s_axis_tready is high only while the
// block is idle, so a new input is taken only once the previous word has
// left the final step and the controller is back in idle. Each word is
// handled by the scan of one window entry per cycle, then by eight steps
// of trimming, division and output.
// The output register lets a new input word be accepted while the previous
// result still waits; if m_axis_tready stays low, processing holds at the
// final step and no word is lost.
// Reset and any write of cfg_wdata_i fill every window slot with that
// level (0 after reset) and set the write position back to the first slot.
// ----------------------------------------------------------------------------
module sliding_trimmed_mean_filter #(
  parameter int WINDOW = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic signed [stmf_pkg::DATA_W-1:0] s_axis_tdata,  // [15:0] sample
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic signed [stmf_pkg::DATA_W-1:0] m_axis_tdata,  // [15:0] filtered
  input  logic                               cfg_we_i,
  input  logic signed [stmf_pkg::DATA_W-1:0] cfg_wdata_i    // init_level
);
  import stmf_pkg::*;

  stmf_cmd_t cmd;
  stmf_sts_t sts;

  stmf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  stmf_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .filtered_o  (m_axis_tdata)
  );

  // Only one word is in the datapath at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a word is being processed");

  // A waiting result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register loaded while still full");

  // A result is shown only after the datapath has loaded it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.load_out))
    else $error("output valid without a load");

endmodule
